### rtl/pcpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcpt_pkg;

    // coordinate and register widths
    localparam int XY_W   = 24;
    localparam int THR_W  = 48;
    localparam int BAND_W = 23;
    localparam int CFG_DW = 48;
    localparam int CFG_IW = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IW-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_IW-1:0] REG_EDGE_BAND = 1'b1;

    // item modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // Q2.22 constants, one bit wider than a coordinate
    localparam logic signed [XY_W:0] ONE_Q22   = 25'sd4194304;
    localparam logic signed [XY_W:0] Q22_MAX_W = 25'sd8388607;
    localparam logic signed [XY_W:0] Q22_MIN_W = -25'sd8388608;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_INS_DONE,
        ST_SCAN,
        ST_Q_DONE
    } t_state;

    // which entry of an insert is being written
    typedef enum logic [1:0] {
        PH_BASE,
        PH_PLUS,
        PH_MINUS
    } t_phase;

    typedef struct packed {
        logic   start;       // capture item, clear per-item state
        logic   ins_en;      // write one insert entry
        t_phase phase;
        logic   ins_result;  // load insert result
        logic   scan_en;     // run the query scan
        logic   q_result;    // load final query result
    } t_cmd;

    typedef struct packed {
        logic out_busy;   // output register holds a result that is not taken this cycle
        logic scan_done;  // nothing left to scan or touch limit reached
    } t_status;

endpackage

`default_nettype wire

### rtl/pcpt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pcpt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/pcpt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pcpt_datapath #(
    parameter int CAPACITY  = 1024,
    parameter int MAX_TOUCH = 3
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pcpt_pkg::CFG_IW-1:0]       i_cfg_idx,
    input  wire logic [pcpt_pkg::CFG_DW-1:0]       i_cfg_data,
    input  wire logic signed [pcpt_pkg::XY_W-1:0]  i_x_pos,
    input  wire logic signed [pcpt_pkg::XY_W-1:0]  i_y_pos,
    input  wire pcpt_pkg::t_cmd                    i_cmd,
    output pcpt_pkg::t_status                      o_status,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [pcpt_pkg::XY_W-1:0]       o_out_x,
    output logic signed [pcpt_pkg::XY_W-1:0]       o_out_y,
    output logic                                   o_found,
    output logic [1:0]                             o_count,
    output logic                                   o_overflow,
    output logic                                   o_last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NW = $clog2(MAX_TOUCH + 1);
    localparam int XW = pcpt_pkg::XY_W;
    localparam int SW = 2 * (XW + 1);

    // configuration registers
    logic [pcpt_pkg::THR_W-1:0]  r_thr;
    logic [pcpt_pkg::BAND_W-1:0] r_band;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= '0;
            r_band <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcpt_pkg::REG_THRESHOLD: r_thr  <= i_cfg_data[pcpt_pkg::THR_W-1:0];
                pcpt_pkg::REG_EDGE_BAND: r_band <= i_cfg_data[pcpt_pkg::BAND_W-1:0];
                default: ;
            endcase
        end
    end

    // captured item coordinates
    logic signed [XW-1:0] r_qx;
    logic signed [XW-1:0] r_qy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_qx <= i_x_pos;
            r_qy <= i_y_pos;
        end
    end

    // image decisions and saturated image coordinates
    logic signed [XW:0]   qx_w;
    logic signed [XW:0]   band_w;
    logic signed [XW:0]   xp_w;
    logic signed [XW:0]   xm_w;
    logic signed [XW-1:0] xp_sat;
    logic signed [XW-1:0] xm_sat;
    logic                 img_lo;
    logic                 img_hi;

    always_comb begin
        qx_w   = {r_qx[XW-1], r_qx};
        band_w = $signed({2'b00, r_band});
        img_lo = qx_w <= band_w;
        img_hi = qx_w >= (pcpt_pkg::ONE_Q22 - band_w);
        xp_w   = qx_w + pcpt_pkg::ONE_Q22;
        xm_w   = qx_w - pcpt_pkg::ONE_Q22;
        xp_sat = (xp_w > pcpt_pkg::Q22_MAX_W) ? pcpt_pkg::Q22_MAX_W[XW-1:0] : xp_w[XW-1:0];
        xm_sat = (xm_w < pcpt_pkg::Q22_MIN_W) ? pcpt_pkg::Q22_MIN_W[XW-1:0] : xm_w[XW-1:0];
    end

    // insert entry selection
    logic                 ins_want;
    logic signed [XW-1:0] ins_x;
    logic                 full;
    logic                 wr_en;

    logic [CW-1:0] r_count;
    logic [1:0]    r_written;
    logic          r_ovf;

    always_comb begin
        case (i_cmd.phase)
            pcpt_pkg::PH_BASE: begin
                ins_want = 1'b1;
                ins_x    = r_qx;
            end
            pcpt_pkg::PH_PLUS: begin
                ins_want = img_lo;
                ins_x    = xp_sat;
            end
            pcpt_pkg::PH_MINUS: begin
                ins_want = img_hi;
                ins_x    = xm_sat;
            end
            default: begin
                ins_want = 1'b0;
                ins_x    = r_qx;
            end
        endcase
        full  = r_count == CW'(CAPACITY);
        wr_en = i_cmd.ins_en && ins_want && !full;
    end

    // fill count and per-insert tallies
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_written <= '0;
            r_ovf     <= 1'b0;
        end else if (i_cmd.start) begin
            r_written <= '0;
            r_ovf     <= 1'b0;
        end else if (i_cmd.ins_en && ins_want) begin
            if (full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count   <= r_count + 1'b1;
                r_written <= r_written + 1'b1;
            end
        end
    end

    // scan pipeline control
    logic          out_busy;
    logic          issue;
    logic          stall;
    logic          adv;
    logic          take_hit;
    logic          below_max;
    logic [CW-1:0] r_rd_addr;
    logic [NW-1:0] r_n;
    logic          r_v0, r_v1, r_v2, r_v3;
    logic          r_hit3;
    logic          r_pend_valid;

    always_comb begin
        out_busy  = o_out_valid && !i_out_ready;
        below_max = r_n < NW'(MAX_TOUCH);
        issue     = r_rd_addr < r_count;
        stall     = r_v3 && r_hit3 && below_max && r_pend_valid && out_busy;
        adv       = i_cmd.scan_en && !stall;
        take_hit  = adv && r_v3 && r_hit3 && below_max;
        o_status.out_busy  = out_busy;
        o_status.scan_done = !below_max || (!issue && !r_v0 && !r_v1 && !r_v2 && !r_v3);
    end

    // point store, {y, x}
    logic [2*XW-1:0] rdata;

    pcpt_ram #(
        .WIDTH (2 * XW),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_qy, ins_x}),
        .i_re    (adv && issue),
        .i_raddr (r_rd_addr[AW-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr <= '0;
            r_n       <= '0;
            r_v0      <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
        end else if (i_cmd.start) begin
            r_rd_addr <= '0;
            r_n       <= '0;
            r_v0      <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
        end else begin
            if (adv) begin
                r_v0 <= issue;
                r_v1 <= r_v0;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                if (issue) begin
                    r_rd_addr <= r_rd_addr + 1'b1;
                end
            end
            if (take_hit) begin
                r_n <= r_n + 1'b1;
            end
        end
    end

    // stage 1 differences and the stage 3 squared distance
    logic signed [XW-1:0] sx;
    logic signed [XW-1:0] sy;
    logic signed [XW:0]   dx;
    logic signed [XW:0]   dy;
    logic [XW:0]          r_ax1, r_ay1;
    logic [XW-1:0]        r_px1, r_py1;
    logic [SW-1:0]        r_sqx2, r_sqy2;
    logic [XW-1:0]        r_px2, r_py2;
    logic [XW-1:0]        r_px3, r_py3;
    logic [SW:0]          d2;

    always_comb begin
        sx = rdata[XW-1:0];
        sy = rdata[2*XW-1:XW];
        dx = {r_qx[XW-1], r_qx} - {sx[XW-1], sx};
        dy = {r_qy[XW-1], r_qy} - {sy[XW-1], sy};
        d2 = {1'b0, r_sqx2} + {1'b0, r_sqy2};
    end

    // stages 1 to 3: abs, squares, sum and threshold compare
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ax1  <= dx[XW] ? -dx : dx;
            r_ay1  <= dy[XW] ? -dy : dy;
            r_px1  <= sx;
            r_py1  <= sy;
            r_sqx2 <= r_ax1 * r_ax1;
            r_sqy2 <= r_ay1 * r_ay1;
            r_px2  <= r_px1;
            r_py2  <= r_py1;
            r_hit3 <= d2 <= {{(SW + 1 - pcpt_pkg::THR_W){1'b0}}, r_thr};
            r_px3  <= r_px2;
            r_py3  <= r_py2;
        end
    end

    // pending touch, held until we know whether it is the last one
    logic [XW-1:0] r_pend_x, r_pend_y;
    logic [1:0]    r_pend_cnt;
    logic [NW:0]   n_plus;

    assign n_plus = {1'b0, r_n} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.start || i_cmd.q_result) begin
            r_pend_valid <= 1'b0;
        end else if (take_hit) begin
            r_pend_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_hit) begin
            r_pend_x   <= r_px3;
            r_pend_y   <= r_py3;
            r_pend_cnt <= n_plus[1:0];
        end
    end

    // output register
    logic push_pend;

    assign push_pend = take_hit && r_pend_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.ins_result || i_cmd.q_result || push_pend) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_result) begin
            o_out_x    <= '0;
            o_out_y    <= '0;
            o_found    <= 1'b0;
            o_count    <= r_written;
            o_overflow <= r_ovf;
            o_last     <= 1'b1;
        end else if (i_cmd.q_result) begin
            o_out_x    <= r_pend_valid ? r_pend_x : '0;
            o_out_y    <= r_pend_valid ? r_pend_y : '0;
            o_found    <= r_pend_valid;
            o_count    <= r_pend_valid ? r_pend_cnt : 2'b00;
            o_overflow <= 1'b0;
            o_last     <= 1'b1;
        end else if (push_pend) begin
            o_out_x    <= r_pend_x;
            o_out_y    <= r_pend_y;
            o_found    <= 1'b1;
            o_count    <= r_pend_cnt;
            o_overflow <= 1'b0;
            o_last     <= 1'b0;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    a_touch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW'(MAX_TOUCH))
        else $error("touch count beyond limit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_pend |-> !out_busy)
        else $error("pending touch pushed over an untaken result");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_found || o_last))
        else $error("result neither a touch nor final");

endmodule

`default_nettype wire

### rtl/pcpt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pcpt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_mode,
    output logic                   o_in_ready,
    input  wire pcpt_pkg::t_status i_status,
    output pcpt_pkg::t_cmd         o_cmd
);

    pcpt_pkg::t_state r_state, n_state;
    pcpt_pkg::t_phase r_phase, n_phase;

    // state and insert step registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcpt_pkg::ST_IDLE;
            r_phase <= pcpt_pkg::PH_BASE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // next state and commands
    always_comb begin
        n_state          = r_state;
        n_phase          = r_phase;
        o_in_ready       = 1'b0;
        o_cmd.start      = 1'b0;
        o_cmd.ins_en     = 1'b0;
        o_cmd.phase      = r_phase;
        o_cmd.ins_result = 1'b0;
        o_cmd.scan_en    = 1'b0;
        o_cmd.q_result   = 1'b0;
        case (r_state)
            pcpt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_phase     = pcpt_pkg::PH_BASE;
                    n_state     = (i_mode == pcpt_pkg::MODE_QUERY) ? pcpt_pkg::ST_SCAN
                                                                   : pcpt_pkg::ST_INSERT;
                end
            end
            pcpt_pkg::ST_INSERT: begin
                o_cmd.ins_en = 1'b1;
                case (r_phase)
                    pcpt_pkg::PH_BASE:  n_phase = pcpt_pkg::PH_PLUS;
                    pcpt_pkg::PH_PLUS:  n_phase = pcpt_pkg::PH_MINUS;
                    default: begin
                        n_phase = pcpt_pkg::PH_BASE;
                        n_state = pcpt_pkg::ST_INS_DONE;
                    end
                endcase
            end
            pcpt_pkg::ST_INS_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.ins_result = 1'b1;
                    n_state          = pcpt_pkg::ST_IDLE;
                end
            end
            pcpt_pkg::ST_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_status.scan_done) begin
                    n_state = pcpt_pkg::ST_Q_DONE;
                end
            end
            pcpt_pkg::ST_Q_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.q_result = 1'b1;
                    n_state        = pcpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pcpt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/periodic_contact_point_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake                | payload
// ---------+--------------------------+---------------------------------------------
// input    | i_in_valid / o_in_ready  | i_mode, i_x_pos, i_y_pos
// output   | o_out_valid / i_out_ready| o_out_x, o_out_y, o_found, o_count,
//          |                          | o_overflow, o_last
// config   | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// insert: three store write steps, one per cycle, then the result load; the next
// input can be taken in the cycle after the result load
// query: the store's single read port is swept one entry per cycle while the scan is not
// held, through a four stage distance pipeline, ending early at MAX_TOUCH touches.
// synchronous active-low reset empties the store by zeroing the fill count; no clear pass.
// a stalled output holds the scan only when a new touch arrives while one is pending;
// every result load also waits for the output register to free

module periodic_contact_point_table_unit #(
    parameter int CAPACITY  = 1024,
    parameter int MAX_TOUCH = 3
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pcpt_pkg::CFG_IW-1:0]       i_cfg_idx,
    input  wire logic [pcpt_pkg::CFG_DW-1:0]       i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_mode,
    input  wire logic signed [pcpt_pkg::XY_W-1:0]  i_x_pos,
    input  wire logic signed [pcpt_pkg::XY_W-1:0]  i_y_pos,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [pcpt_pkg::XY_W-1:0]       o_out_x,
    output logic signed [pcpt_pkg::XY_W-1:0]       o_out_y,
    output logic                                   o_found,
    output logic [1:0]                             o_count,
    output logic                                   o_overflow,
    output logic                                   o_last
);

    pcpt_pkg::t_cmd    cmd;
    pcpt_pkg::t_status status;

    // sequencer
    pcpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // store, scan pipeline and output register
    pcpt_datapath #(
        .CAPACITY  (CAPACITY),
        .MAX_TOUCH (MAX_TOUCH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_x_pos     (i_x_pos),
        .i_y_pos     (i_y_pos),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_found     (o_found),
        .o_count     (o_count),
        .o_overflow  (o_overflow),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire
